// ----- rtl/dvi_scanline_segment_sequencer_macros.svh -----
// ----------------------------------------------------------------------------
// dvi_scanline_segment_sequencer_macros
// assertion macros used by the sequencer rtl
// ----------------------------------------------------------------------------
`ifndef DVI_SCANLINE_SEGMENT_SEQUENCER_MACROS_SVH
`define DVI_SCANLINE_SEGMENT_SEQUENCER_MACROS_SVH

// same-cycle implication, checked out of reset
`define DSS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define DSS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/dss_pkg.sv -----
// ----------------------------------------------------------------------------
// dss_pkg
// timing constants, codes and types of the scanline segment sequencer
// ----------------------------------------------------------------------------
package dss_pkg;

  // vertical timing
  localparam int unsigned V_FRONT_PORCH      = 10;
  localparam int unsigned V_SYNC_LINES       = 2;
  localparam int unsigned V_BACK_PORCH       = 33;
  localparam int unsigned V_ACTIVE_LINES     = 480;
  localparam int unsigned LINE_PIXELS        = 640;
  localparam int unsigned SYNC_END           = V_FRONT_PORCH + V_SYNC_LINES;
  localparam int unsigned BLANK_START_ACTIVE = SYNC_END + V_BACK_PORCH;
  localparam int unsigned FRAME_LINES        = BLANK_START_ACTIVE + V_ACTIVE_LINES;

  // field widths
  localparam int unsigned LINE_W  = 10;
  localparam int unsigned CMP_W   = LINE_W + 2;
  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned WORDS_W = 9;
  localparam int unsigned FRAME_W = 32;
  localparam int unsigned BPP_W   = 2;
  localparam int unsigned SCALE_W = 2;
  localparam int unsigned CFG_W   = 2;
  localparam int unsigned ROW_W   = $clog2(V_ACTIVE_LINES);

  // divide by three through a reciprocal, exact for every row index
  localparam int unsigned DIV3_SHIFT = ROW_W + 2;
  localparam int unsigned DIV3_MUL   = ((2 ** DIV3_SHIFT) + 2) / 3;
  localparam int unsigned PROD_W     = ROW_W + DIV3_SHIFT;

  // word counts
  localparam int unsigned WORDS_MAX    = 2 ** WORDS_W - 1;
  localparam int unsigned PIX_WORDS_1  = (LINE_PIXELS / 4 > WORDS_MAX) ? WORDS_MAX
                                                                      : LINE_PIXELS / 4;
  localparam int unsigned PIX_WORDS_2  = (LINE_PIXELS * 2 / 4 > WORDS_MAX) ? WORDS_MAX
                                                                          : LINE_PIXELS * 2 / 4;
  localparam logic [WORDS_W-1:0] BLANK_LIST_WORDS = WORDS_W'(7);
  localparam logic [WORDS_W-1:0] CMD_LIST_WORDS   = WORDS_W'(9);

  // configuration register indexes
  localparam logic [CFG_W-1:0] CFG_FRAME_BASE  = 2'd0;
  localparam logic [CFG_W-1:0] CFG_BYTES_PIXEL = 2'd1;
  localparam logic [CFG_W-1:0] CFG_VERT_SCALE  = 2'd2;

  // vertical scale codes that divide
  localparam logic [SCALE_W-1:0] SCALE_HALF  = 2'd2;
  localparam logic [SCALE_W-1:0] SCALE_THIRD = 2'd3;

  typedef enum logic [1:0] {
    KIND_VSYNC_ON  = 2'd0,
    KIND_VSYNC_OFF = 2'd1,
    KIND_CMD_LIST  = 2'd2,
    KIND_PIXEL     = 2'd3
  } seg_kind_t;

  typedef struct packed {
    seg_kind_t            kind;
    logic [LINE_W-1:0]    line;
    logic [FRAME_W-1:0]   frames;
    logic                 wrapped;
  } seg_info_t;

endpackage

// ----- rtl/dss_seq_ctrl.sv -----
// ----------------------------------------------------------------------------
// dss_seq_ctrl
// line counter, command list flag and frame counter; picks the next segment
// ----------------------------------------------------------------------------
module dss_seq_ctrl
  import dss_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step,
  output seg_info_t seg
);

  logic [LINE_W-1:0]  line_r, line_nxt;
  logic               cmd_sent_r, cmd_sent_nxt;
  logic [FRAME_W-1:0] frames_r, frames_nxt;

  logic [CMP_W-1:0]   line_ext;
  logic [CMP_W-1:0]   line_inc;
  seg_kind_t          kind;
  logic               advance;
  logic               wrap;

  assign line_ext = CMP_W'(line_r);
  assign line_inc = line_ext + CMP_W'(1);

  always_comb begin
    if (line_ext >= CMP_W'(V_FRONT_PORCH) && line_ext < CMP_W'(SYNC_END)) begin
      kind = KIND_VSYNC_ON;
    end else if (line_ext < CMP_W'(BLANK_START_ACTIVE)) begin
      kind = KIND_VSYNC_OFF;
    end else if (!cmd_sent_r) begin
      kind = KIND_CMD_LIST;
    end else begin
      kind = KIND_PIXEL;
    end
  end

  // the command list half of an active line holds the line
  assign advance = (kind != KIND_CMD_LIST);
  assign wrap    = advance && (line_inc >= CMP_W'(FRAME_LINES));

  always_comb begin
    line_nxt     = line_r;
    cmd_sent_nxt = cmd_sent_r;
    frames_nxt   = frames_r + FRAME_W'(wrap);
    if (step) begin
      cmd_sent_nxt = (kind == KIND_CMD_LIST);
      if (advance) begin
        line_nxt = wrap ? '0 : line_inc[LINE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_r     <= '0;
      cmd_sent_r <= 1'b0;
      frames_r   <= '0;
    end else begin
      line_r     <= line_nxt;
      cmd_sent_r <= cmd_sent_nxt;
      if (step) begin
        frames_r <= frames_nxt;
      end
    end
  end

  assign seg.kind    = kind;
  assign seg.line    = line_r;
  assign seg.frames  = frames_nxt;
  assign seg.wrapped = wrap;

endmodule

// ----- rtl/dss_row_addr.sv -----
// ----------------------------------------------------------------------------
// dss_row_addr
// framebuffer row address and word count of the chosen segment
// ----------------------------------------------------------------------------
module dss_row_addr
  import dss_pkg::*;
(
  input  seg_info_t           seg,
  input  logic [ADDR_W-1:0]   frame_base,
  input  logic [BPP_W-1:0]    bytes_per_pixel,
  input  logic [SCALE_W-1:0]  vertical_scale,
  output logic [ADDR_W-1:0]   read_address,
  output logic [WORDS_W-1:0]  transfer_words
);

  logic [CMP_W-1:0]  row_diff;
  logic [ROW_W-1:0]  row;
  logic [PROD_W-1:0] div3_prod;
  logic [ROW_W-1:0]  row_sel;
  logic [ADDR_W-1:0] row_ofs;
  logic              wide_pixel;

  // zero and one mean eight-bit pixels, two and three sixteen-bit
  assign wide_pixel = bytes_per_pixel[1];

  assign row_diff  = CMP_W'(seg.line) - CMP_W'(BLANK_START_ACTIVE);
  assign row       = row_diff[ROW_W-1:0];
  assign div3_prod = PROD_W'(row) * PROD_W'(DIV3_MUL);

  always_comb begin
    case (vertical_scale)
      SCALE_HALF:  row_sel = row >> 1;
      SCALE_THIRD: row_sel = div3_prod[PROD_W-1 -: ROW_W];
      default:     row_sel = row;
    endcase
  end

  assign row_ofs = ADDR_W'(row_sel) * ADDR_W'(LINE_PIXELS);

  always_comb begin
    read_address = '0;
    case (seg.kind)
      KIND_PIXEL: begin
        read_address   = frame_base + (wide_pixel ? (row_ofs << 1) : row_ofs);
        transfer_words = wide_pixel ? WORDS_W'(PIX_WORDS_2) : WORDS_W'(PIX_WORDS_1);
      end
      KIND_CMD_LIST: transfer_words = CMD_LIST_WORDS;
      default:       transfer_words = BLANK_LIST_WORDS;
    endcase
  end

endmodule

// ----- rtl/dvi_scanline_segment_sequencer.sv -----
// ----------------------------------------------------------------------------
// dvi_scanline_segment_sequencer
// picks the next scanline segment and dma channel on every transfer-done event
// ----------------------------------------------------------------------------
// Each transfer on the input channel is one transfer-done event; it yields
// exactly one result transfer naming the other channel and the next segment.
// The block takes one event per clock while its results are taken; each
// event passes an input register, then the segment decision against
// the line / command-list state with the row address multiply, then the
// result register. The rate is set by that single decision stage, which
// updates the line and frame counters once per event. An input transfer is
// taken while an earlier result still waits, as long as the input register
// is empty or hands its event on to the result register in the same cycle.
// Configuration writes are always accepted
// (cfg_ready is tied high); write them only while no event is in flight.
// ----------------------------------------------------------------------------
`include "dvi_scanline_segment_sequencer_macros.svh"

module dvi_scanline_segment_sequencer
  import dss_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // transfer-done events
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_finished_channel,
  // segment results
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_next_channel,
  output logic [1:0]         out_segment_kind,
  output logic [ADDR_W-1:0]  out_read_address,
  output logic [WORDS_W-1:0] out_transfer_words,
  output logic [LINE_W-1:0]  out_line_number,
  output logic [FRAME_W-1:0] out_frames_done,
  output logic               out_frame_wrapped,
  // register writes
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CFG_W-1:0]   cfg_index,
  input  logic [ADDR_W-1:0]  cfg_data
);

  // configuration registers
  logic [ADDR_W-1:0]  frame_base_r;
  logic [BPP_W-1:0]   bpp_r;
  logic [SCALE_W-1:0] scale_r;

  // input register
  logic               s1_valid_r;
  logic               s1_fin_r;
  logic               s1_go;

  // result register
  logic               out_valid_r;
  logic               next_chan_r;
  seg_kind_t          kind_r;
  logic [ADDR_W-1:0]  addr_r;
  logic [WORDS_W-1:0] words_r;
  logic [LINE_W-1:0]  line_r;
  logic [FRAME_W-1:0] frames_r;
  logic               wrapped_r;

  seg_info_t          seg;
  logic [ADDR_W-1:0]  seg_addr;
  logic [WORDS_W-1:0] seg_words;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_base_r <= '0;
      bpp_r        <= BPP_W'(1);
      scale_r      <= SCALE_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_FRAME_BASE:  frame_base_r <= cfg_data;
        CFG_BYTES_PIXEL: bpp_r        <= cfg_data[BPP_W-1:0];
        CFG_VERT_SCALE:  scale_r      <= cfg_data[SCALE_W-1:0];
        default: ;  // index beyond the list: ignored
      endcase
    end
  end

  // the decision stage moves on when the result register is empty or draining
  assign s1_go    = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_fin_r <= in_finished_channel;
    end
  end

  // line, command-list and frame state, stepped once per event
  dss_seq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (s1_go),
    .seg   (seg)
  );

  // row address and word count
  dss_row_addr u_addr (
    .seg             (seg),
    .frame_base      (frame_base_r),
    .bytes_per_pixel (bpp_r),
    .vertical_scale  (scale_r),
    .read_address    (seg_addr),
    .transfer_words  (seg_words)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      next_chan_r <= ~s1_fin_r;
      kind_r      <= seg.kind;
      addr_r      <= seg_addr;
      words_r     <= seg_words;
      line_r      <= seg.line;
      frames_r    <= seg.frames;
      wrapped_r   <= seg.wrapped;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_next_channel   = next_chan_r;
  assign out_segment_kind   = kind_r;
  assign out_read_address   = addr_r;
  assign out_transfer_words = words_r;
  assign out_line_number    = line_r;
  assign out_frames_done    = frames_r;
  assign out_frame_wrapped  = wrapped_r;

  // input side only stalls behind a held result
  `DSS_ASSERT_IMPL(a_stall_cause, !in_ready, out_valid_r && !out_ready,
    "input stalled without a held result")
  // the line counter stays inside the frame
  `DSS_ASSERT_IMPL(a_line_range, 1'b1, CMP_W'(seg.line) < CMP_W'(FRAME_LINES),
    "line counter beyond frame total")
  // a command list is always followed by the pixel half of the same line
  `DSS_ASSERT_NEXT(a_cmd_then_pixel, s1_go && seg.kind == KIND_CMD_LIST,
    seg.kind == KIND_PIXEL, "command list not followed by pixel data")
  // only pixel data carries an address
  `DSS_ASSERT_IMPL(a_addr_zero, out_valid_r && kind_r != KIND_PIXEL, addr_r == '0,
    "non-pixel segment with nonzero address")
  // a wrap is reported on the last line of the frame
  `DSS_ASSERT_IMPL(a_wrap_line, out_valid_r && wrapped_r,
    line_r == LINE_W'(FRAME_LINES - 1), "frame wrap off the last line")

endmodule

// ----- tb/sv/tb_dvi_scanline_segment_sequencer.sv -----
// ----------------------------------------------------------------------------
// tb_dvi_scanline_segment_sequencer
// self-checking bench for the ping-pong scanline segment sequencer
// ----------------------------------------------------------------------------
// Transfer-done events go in with random gaps and results come out with
// random stalls. A scoreboard keeps its own line counter, command-list flag,
// frame counter and register copies. It works out each segment when an event
// is accepted and checks the results in order. Register settings change
// between phases, only once the pipeline is empty. The run covers the porch
// and sync lines and a good part of the active lines of the first frame.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_dvi_scanline_segment_sequencer;
  import dss_pkg::*;

  // register index past the end of the list, writes to it are dropped
  localparam logic [CFG_W-1:0] CFG_SPARE = 2'd3;
  localparam int unsigned PHASES = 12;

  // one expected segment
  typedef struct {
    logic               next_ch;
    seg_kind_t          kind;
    logic [ADDR_W-1:0]  addr;
    logic [WORDS_W-1:0] words;
    logic [LINE_W-1:0]  line;
    logic [FRAME_W-1:0] frames;
    logic               wrapped;
  } segment_t;

  // --------------------------------------------------------------------------
  // scoreboard: segment predictor plus in-order result check
  // --------------------------------------------------------------------------
  class segment_scoreboard;
    segment_t           pending_segments[$];
    int unsigned        errors;
    // register copies, reset values
    logic [ADDR_W-1:0]  base_addr;
    logic [BPP_W-1:0]   bpp_reg;
    logic [SCALE_W-1:0] scale_reg;
    // sequencer state
    logic [LINE_W-1:0]  line_q;
    logic               cmd_list_sent;
    logic [FRAME_W-1:0] frames_q;

    function new();
      errors        = 0;
      base_addr     = '0;
      bpp_reg       = BPP_W'(1);
      scale_reg     = SCALE_W'(1);
      line_q        = '0;
      cmd_list_sent = 1'b0;
      frames_q      = '0;
    endfunction

    function void set_register(logic [CFG_W-1:0] idx, logic [ADDR_W-1:0] data);
      case (idx)
        CFG_FRAME_BASE:  base_addr = data;
        CFG_BYTES_PIXEL: bpp_reg   = data[BPP_W-1:0];
        CFG_VERT_SCALE:  scale_reg = data[SCALE_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return pending_segments.size();
    endfunction

    // work out the segment for one accepted event and advance the state
    function void note_event(logic fin);
      segment_t    s;
      int unsigned row;
      int unsigned bpp;
      int unsigned nxt;
      int unsigned pix_words;
      s.next_ch = ~fin;
      s.line    = line_q;
      s.addr    = '0;
      s.wrapped = 1'b0;
      if (line_q >= V_FRONT_PORCH && line_q < SYNC_END) begin
        s.kind  = KIND_VSYNC_ON;
        s.words = BLANK_LIST_WORDS;
      end else if (line_q < BLANK_START_ACTIVE) begin
        // front porch and back porch
        s.kind  = KIND_VSYNC_OFF;
        s.words = BLANK_LIST_WORDS;
      end else if (!cmd_list_sent) begin
        s.kind        = KIND_CMD_LIST;
        s.words       = CMD_LIST_WORDS;
        cmd_list_sent = 1'b1;
      end else begin
        // zero reads as one byte, three as two
        bpp = (bpp_reg == 0) ? 1 : ((bpp_reg > 2) ? 2 : bpp_reg);
        row = line_q - BLANK_START_ACTIVE;
        // scale zero and one leave the row alone
        if (scale_reg > 1) row = row / scale_reg;
        s.kind    = KIND_PIXEL;
        s.addr    = base_addr + ADDR_W'(row * LINE_PIXELS * bpp);
        pix_words = LINE_PIXELS * bpp / 4;
        if (pix_words > WORDS_MAX) pix_words = WORDS_MAX;
        s.words       = pix_words[WORDS_W-1:0];
        cmd_list_sent = 1'b0;
      end
      // the command-list half of an active line holds the counter
      if (!cmd_list_sent) begin
        nxt = line_q + 1;
        if (nxt >= FRAME_LINES) nxt = 0;
        line_q = LINE_W'(nxt);
        if (nxt == 0) begin
          frames_q  = frames_q + 1'b1;
          s.wrapped = 1'b1;
        end
      end
      s.frames = frames_q;
      pending_segments.push_back(s);
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
      errors++;
    endtask

    task check_result(logic nch, logic [1:0] kind, logic [ADDR_W-1:0] addr,
                      logic [WORDS_W-1:0] words, logic [LINE_W-1:0] line,
                      logic [FRAME_W-1:0] frames, logic wrapped);
      segment_t s;
      if (pending_segments.size() == 0) begin
        report_mismatch("unexpected result, line", line, 0);
        return;
      end
      s = pending_segments.pop_front();
      if (nch !== s.next_ch)     report_mismatch("next_channel", nch, s.next_ch);
      if (kind !== s.kind)       report_mismatch("segment_kind", kind, s.kind);
      if (addr !== s.addr)       report_mismatch("read_address", addr, s.addr);
      if (words !== s.words)     report_mismatch("transfer_words", words, s.words);
      if (line !== s.line)       report_mismatch("line_number", line, s.line);
      if (frames !== s.frames)   report_mismatch("frames_done", frames, s.frames);
      if (wrapped !== s.wrapped) report_mismatch("frame_wrapped", wrapped, s.wrapped);
    endtask
  endclass

  // --------------------------------------------------------------------------
  // clock, dut hookup
  // --------------------------------------------------------------------------
  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic               in_finished_channel;
  logic               out_valid;
  logic               out_ready;
  logic               out_next_channel;
  logic [1:0]         out_segment_kind;
  logic [ADDR_W-1:0]  out_read_address;
  logic [WORDS_W-1:0] out_transfer_words;
  logic [LINE_W-1:0]  out_line_number;
  logic [FRAME_W-1:0] out_frames_done;
  logic               out_frame_wrapped;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CFG_W-1:0]   cfg_index;
  logic [ADDR_W-1:0]  cfg_data;

  segment_scoreboard  sb;
  // set for phases where neither side idles
  bit                 steady;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  dvi_scanline_segment_sequencer u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_finished_channel (in_finished_channel),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_next_channel    (out_next_channel),
    .out_segment_kind    (out_segment_kind),
    .out_read_address    (out_read_address),
    .out_transfer_words  (out_transfer_words),
    .out_line_number     (out_line_number),
    .out_frames_done     (out_frames_done),
    .out_frame_wrapped   (out_frame_wrapped),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  // --------------------------------------------------------------------------
  // drivers
  // --------------------------------------------------------------------------

  // one transfer-done event; valid stays up after the transfer so that a
  // back-to-back event needs no second assignment in the same step
  task automatic send_event(input logic fin);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid            <= 1'b1;
    in_finished_channel <= fin;
    do @(posedge clk); while (!in_ready);
    sb.note_event(fin);
  endtask

  // hold off the sender until every expected segment is back
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    // two-stage pipe, let it idle before touching registers
    repeat (4) @(posedge clk);
  endtask

  // register write, cfg_valid is left high for a following write
  task automatic write_reg(input logic [CFG_W-1:0] idx, input logic [ADDR_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.set_register(idx, data);
  endtask

  task automatic program_regs(input logic [ADDR_W-1:0] base, input logic [BPP_W-1:0] bpp,
                              input logic [SCALE_W-1:0] scale, input bit spare);
    write_reg(CFG_FRAME_BASE, base);
    // upper data bits are junk, only the low field counts
    write_reg(CFG_BYTES_PIXEL, {30'($urandom), bpp});
    write_reg(CFG_VERT_SCALE, {30'($urandom), scale});
    if (spare) write_reg(CFG_SPARE, $urandom);
    cfg_valid <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // result side: random stalls, every transfer checked in order
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned stall;
    out_ready = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      sb.check_result(out_next_channel, out_segment_kind, out_read_address,
                      out_transfer_words, out_line_number, out_frames_done,
                      out_frame_wrapped);
    end
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned        n;
    int unsigned        sel;
    logic [ADDR_W-1:0]  base;
    rst_n               = 1'b0;
    in_valid            = 1'b0;
    in_finished_channel = 1'b0;
    cfg_valid           = 1'b0;
    cfg_index           = '0;
    cfg_data            = '0;
    steady              = 1'b0;
    sb                  = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset registers, both channels, through the first porch
    // lines and the vsync-on lines into the back porch
    for (int i = 0; i < 20; i++) send_event(i[0]);
    wait_drain();

    // phases: each walks through a new register setting, zero and three
    // for bytes per pixel and vertical scale included, base at both ends
    for (int p = 0; p < PHASES; p++) begin
      sel = (p + p / 4) % 3;
      case (sel)
        0:       base = '0;
        1:       base = '1;
        default: base = $urandom;
      endcase
      program_regs(base, BPP_W'(p % 4), SCALE_W'((p / 2) % 4), p[0]);
      steady = ($urandom_range(0, 3) == 0);
      n = $urandom_range(60, 80);
      for (int i = 0; i < n; i++) begin
        // now and then let the pipe run dry mid-phase
        if ($urandom_range(0, 63) == 0) wait_drain();
        send_event(1'($urandom_range(0, 1)));
      end
      wait_drain();
    end

    steady = 1'b0;
    wait_drain();
    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin : watchdog
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
